// ===== hdl/lbpm_pkg.sv =====
package lbpm_pkg;

   // Fixed sizes of the item fields.
   localparam int SAMPLE_W   = 16;
   localparam int PEAK_W     = 15;
   localparam int PEAK_SHIFT = 7;
   localparam int K_W        = 8;
   localparam int POS_W      = 8;
   localparam int BAND_COUNT = 16;
   localparam int BAND_W     = 4;
   localparam int GAIN_W     = 16;
   localparam int LEVEL_W    = 19;

   // Log table precision and derived widths.
   localparam int LOG_FRACTION_BITS = 13;
   localparam int LN_W    = LOG_FRACTION_BITS + 3;
   localparam int PROD_W  = LN_W + GAIN_W;
   localparam int SHIFT_W = PROD_W - LOG_FRACTION_BITS;

   localparam logic [LEVEL_W-1:0]  LEVEL_MAX  = 19'd524287;
   localparam logic [GAIN_W-1:0]   GAIN_RESET = 16'd11819;
   localparam logic [POS_W-1:0]    FRAME_SPAN = 8'd255;
   localparam logic [BAND_W-1:0]   BAND_TOP   = 4'(BAND_COUNT - 1);
   localparam logic [63:0]         LN2_Q32    = 64'd2977044472;

   // Depth of the command queue between front and back.
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // First sample position of each band, with the frame end on top.
   typedef logic [BAND_COUNT:0][POS_W-1:0] edge_type;
   localparam edge_type BAND_EDGE = {
      8'd255, 8'd187, 8'd137, 8'd101, 8'd74, 8'd54, 8'd40, 8'd28, 8'd20,
      8'd14, 8'd10, 8'd7, 8'd5, 8'd3, 8'd2, 8'd1, 8'd0
   };

   typedef logic [255:0][LN_W-1:0] ln_table_type;

   // One band to be reported: its number and its shifted peak.
   typedef struct packed {
      logic [BAND_W-1:0] band;
      logic [K_W-1:0]    k;
   } cmd_type;

   typedef enum logic [0:0] {
      FE_TAKE,
      FE_FLUSH
   } fe_state_type;

   // Last sample position that belongs to a band.
   function automatic logic [POS_W-1:0] band_last(input logic [BAND_W-1:0] band);
      logic [BAND_W:0] idx;
      idx = {1'b0, band} + 5'd1;
      return BAND_EDGE[idx] - 8'd1;
   endfunction

   // Natural log of k in Q3.LOG_FRACTION_BITS, through a squaring log2.
   function automatic logic [LN_W-1:0] ln_entry(input int unsigned k);
      logic [63:0] x;
      logic [63:0] frac;
      logic [63:0] p;
      int unsigned n;
      n    = 0;
      frac = 64'd0;
      if (k == 0) begin
         return '0;
      end
      for (int i = 1; i < 8; i++) begin
         if ((k >> i) != 0) begin
            n = i;
         end
      end
      x = 64'(k) << (30 - n);
      for (int i = 0; i < 24; i++) begin
         x    = (x * x) >> 30;
         frac = frac << 1;
         if (x >= 64'h8000_0000) begin
            x    = x >> 1;
            frac = frac | 64'd1;
         end
      end
      p = ((64'(n) << 24) + frac) * LN2_Q32;
      return LN_W'((p + (64'd1 << (55 - LOG_FRACTION_BITS))) >> (56 - LOG_FRACTION_BITS));
   endfunction

   function automatic ln_table_type ln_table_build();
      ln_table_type t;
      for (int i = 0; i < 256; i++) begin
         t[i] = ln_entry(i);
      end
      return t;
   endfunction

   localparam ln_table_type LN_TABLE = ln_table_build();

endpackage

// ===== hdl/lbpm_req_if.sv =====
interface lbpm_req_if import lbpm_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] sample;
   logic                       last_sample;

   modport source (output valid, sample, last_sample, input ready);
   modport sink   (input valid, sample, last_sample, output ready);
endinterface

// ===== hdl/lbpm_rsp_if.sv =====
interface lbpm_rsp_if import lbpm_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [BAND_W-1:0]  band;
   logic [LEVEL_W-1:0] level;
   logic               last_band;

   modport source (output valid, band, level, last_band, input ready);
   modport sink   (input valid, band, level, last_band, output ready);
endinterface

// ===== hdl/lbpm_front.sv =====
module lbpm_front import lbpm_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   lbpm_req_if.sink    req,
   input  logic        q_full,
   output logic        push_valid,
   output cmd_type     push_cmd
);

   fe_state_type state_ff, state_in;
   logic [POS_W-1:0]  pos_ff, pos_in;
   logic [BAND_W:0]   band_ff, band_in;
   logic [PEAK_W-1:0] peak_ff, peak_in;

   logic              accept;
   logic              active;
   logic              close;
   logic [PEAK_W-1:0] peak_new;
   logic [BAND_W:0]   band_next;

   // Classify the offered sample against the current band.
   always_comb begin
      active   = (pos_ff < FRAME_SPAN) && !band_ff[BAND_W];
      close    = active && (pos_ff >= band_last(band_ff[BAND_W-1:0]));
      peak_new = peak_ff;
      if (!req.sample[SAMPLE_W-1] && (req.sample[PEAK_W-1:0] > peak_ff)) begin
         peak_new = req.sample[PEAK_W-1:0];
      end
      band_next = band_ff + {{BAND_W{1'b0}}, close};
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         FE_TAKE: begin
            if (accept && req.last_sample && !band_next[BAND_W]) begin
               state_in = FE_FLUSH;
            end
         end
         FE_FLUSH: begin
            if (!q_full && (band_ff[BAND_W-1:0] == BAND_TOP)) begin
               state_in = FE_TAKE;
            end
         end
         default: state_in = FE_TAKE;
      endcase
   end

   // Handshake and queue writes.
   always_comb begin
      req.ready  = 1'b0;
      push_valid = 1'b0;
      push_cmd   = '{band: band_ff[BAND_W-1:0], k: peak_new[PEAK_W-1:PEAK_SHIFT]};
      case (state_ff)
         FE_TAKE: begin
            req.ready  = !q_full;
            push_valid = accept && close;
         end
         FE_FLUSH: begin
            push_valid = !q_full;
            push_cmd.k = peak_ff[PEAK_W-1:PEAK_SHIFT];
         end
         default: begin
            req.ready  = 1'b0;
            push_valid = 1'b0;
         end
      endcase
   end

   assign accept = req.valid && req.ready;

   // Position, band and peak updates.
   always_comb begin
      pos_in  = pos_ff;
      band_in = band_ff;
      peak_in = peak_ff;
      if (state_ff == FE_TAKE) begin
         if (accept) begin
            if (req.last_sample) begin
               pos_in  = '0;
               band_in = band_next[BAND_W] ? '0 : band_next;
               peak_in = (close || band_next[BAND_W]) ? '0 : peak_new;
            end else begin
               if (pos_ff < FRAME_SPAN) begin
                  pos_in = pos_ff + 8'd1;
               end
               band_in = band_next;
               if (close) begin
                  peak_in = '0;
               end else if (active) begin
                  peak_in = peak_new;
               end
            end
         end
      end else if (!q_full) begin
         // Flush one open band per cycle while the queue is not full; only the first can carry a peak.
         peak_in = '0;
         band_in = (band_ff[BAND_W-1:0] == BAND_TOP) ? '0 : band_ff + 5'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FE_TAKE;
         pos_ff   <= '0;
         band_ff  <= '0;
         peak_ff  <= '0;
      end else begin
         state_ff <= state_in;
         pos_ff   <= pos_in;
         band_ff  <= band_in;
         peak_ff  <= peak_in;
      end
   end

endmodule

// ===== hdl/lbpm_queue.sv =====
module lbpm_queue import lbpm_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push_valid,
   input  cmd_type push_cmd,
   output logic    full,
   input  logic    pop,
   output logic    pop_valid,
   output cmd_type pop_cmd
);

   cmd_type            entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]  count_ff, count_in;
   logic               do_push;
   logic               do_pop;

   assign full      = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_cmd   = entry_ff[rd_ptr_ff];
   assign do_push   = push_valid && !full;
   assign do_pop    = pop && pop_valid;

   // Pointer and fill count updates.
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

// ===== hdl/lbpm_back.sv =====
module lbpm_back import lbpm_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_write_enable,
   input  logic [GAIN_W-1:0] csr_write_data,
   input  logic              q_valid,
   input  cmd_type           q_cmd,
   output logic              q_pop,
   lbpm_rsp_if.source        rsp
);

   logic [GAIN_W-1:0]  gain_ff;
   logic               s1_valid_ff;
   logic [BAND_W-1:0]  s1_band_ff;
   logic [LN_W-1:0]    s1_entry_ff;
   logic               s2_valid_ff;
   logic [BAND_W-1:0]  s2_band_ff;
   logic [PROD_W-1:0]  s2_prod_ff;
   logic               out_valid_ff;
   logic [BAND_W-1:0]  out_band_ff;
   logic [LEVEL_W-1:0] out_level_ff;
   logic [LEVEL_W-1:0] level_in;
   logic [SHIFT_W-1:0] shifted;
   logic               advance;

   // The whole pipeline moves unless a result waits at the output with rsp.ready low.
   assign advance = !out_valid_ff || rsp.ready;
   assign q_pop   = advance && q_valid;

   // Drop the fraction bits and clamp to the level range.
   always_comb begin
      shifted  = SHIFT_W'(s2_prod_ff >> LOG_FRACTION_BITS);
      level_in = (shifted > SHIFT_W'(LEVEL_MAX)) ? LEVEL_MAX : LEVEL_W'(shifted);
   end

   // Gain register.
   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff <= GAIN_RESET;
      end else if (csr_write_enable) begin
         gain_ff <= csr_write_data;
      end
   end

   // Stage valid bits.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff  <= q_valid;
         s2_valid_ff  <= s1_valid_ff;
         out_valid_ff <= s2_valid_ff;
      end
   end

   // Table lookup, gain multiply and output register.
   always_ff @(posedge clock) begin
      if (advance) begin
         s1_band_ff   <= q_cmd.band;
         s1_entry_ff  <= LN_TABLE[q_cmd.k];
         s2_band_ff   <= s1_band_ff;
         s2_prod_ff   <= PROD_W'(s1_entry_ff) * PROD_W'(gain_ff);
         out_band_ff  <= s2_band_ff;
         out_level_ff <= level_in;
      end
   end

   assign rsp.valid     = out_valid_ff;
   assign rsp.band      = out_band_ff;
   assign rsp.level     = out_level_ff;
   assign rsp.last_band = (out_band_ff == BAND_TOP);

endmodule

// ===== hdl/log_band_peak_meter.sv =====
// A band's result goes through the command queue, then the lookup, multiply and output registers.
// Throughput: one sample per cycle while the command queue is not full; a marked sample that leaves
// bands open is followed by a flush of each open band (up to 15) into the queue, with req.ready low.
// The four-entry command queue and the output register absorb rsp.ready stalls.
// Reset (synchronous, active high) clears position, band, peak, queue and pipeline valid bits,
// and loads the gain register with 11819.
module log_band_peak_meter import lbpm_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   lbpm_req_if.sink          req,
   lbpm_rsp_if.source        rsp,
   input  logic              csr_write_enable,
   input  logic [GAIN_W-1:0] csr_write_data
);

   logic    q_full;
   logic    push_valid;
   cmd_type push_cmd;
   logic    q_pop;
   logic    q_valid;
   cmd_type q_cmd;

   // Front: accepts samples, tracks bands, queues band reports.
   lbpm_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req),
      .q_full     (q_full),
      .push_valid (push_valid),
      .push_cmd   (push_cmd)
   );

   // Queue between front and back.
   lbpm_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_cmd   (push_cmd),
      .full       (q_full),
      .pop        (q_pop),
      .pop_valid  (q_valid),
      .pop_cmd    (q_cmd)
   );

   // Back: log lookup, gain and result output.
   lbpm_back u_back (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .q_valid          (q_valid),
      .q_cmd            (q_cmd),
      .q_pop            (q_pop),
      .rsp              (rsp)
   );

endmodule

// ===== hdl/lbpm_checker.sv =====
module lbpm_checker import lbpm_pkg::*; (
   input logic               clock,
   input logic               reset,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic [BAND_W-1:0]  rsp_band,
   input logic [LEVEL_W-1:0] rsp_level,
   input logic               rsp_last_band
);

   logic [BAND_W-1:0] expected_band_ff;

   // Every frame reports bands 0 to 15 in order, so track the next one due.
   always_ff @(posedge clock) begin
      if (reset) begin
         expected_band_ff <= '0;
      end else if (rsp_valid && rsp_ready) begin
         expected_band_ff <= expected_band_ff + 1'b1;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_band) && $stable(rsp_level))
      else $error("result item changed while stalled");

   a_band_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready |-> rsp_band == expected_band_ff)
      else $error("band reported out of order");

   a_last_band: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_last_band == (rsp_band == BAND_TOP))
      else $error("last_band does not match band 15");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

endmodule

bind log_band_peak_meter lbpm_checker u_lbpm_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp.valid),
   .rsp_ready     (rsp.ready),
   .rsp_band      (rsp.band),
   .rsp_level     (rsp.level),
   .rsp_last_band (rsp.last_band)
);
